// ===== hw/rtl/wps_pkg.sv =====
// Shared types and constants for the windowed PID line steering block.
// No dependencies; the RTL uses scoped names, the testbench imports it.
package wps_pkg;

  localparam int WINDOW   = 8;    // ring length, 2..256
  localparam int MAX_TURN = 100;  // steering saturation, 1..1000

  localparam int LEVEL_W = 8;
  localparam int GAIN_W  = 16;
  localparam int STEER_W = 8;
  localparam int ERR_W   = LEVEL_W + 1;
  localparam int DIFF_W  = ERR_W + 1;
  localparam int SUM_W   = $clog2(WINDOW * 255 + 1) + 1;
  localparam int SLOT_W  = $clog2(WINDOW);
  localparam int P_W     = GAIN_W + 1 + ERR_W;
  localparam int I_W     = GAIN_W + 1 + SUM_W;
  localparam int D_W     = GAIN_W + 1 + DIFF_W;
  localparam int ACC_W   = GAIN_W + 1 + SUM_W + 2;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_LEVEL = 3'd0,
    REG_KP_STRAIGHT  = 3'd1,
    REG_KI_STRAIGHT  = 3'd2,
    REG_KD_STRAIGHT  = 3'd3,
    REG_KP_CURVE     = 3'd4,
    REG_KI_CURVE     = 3'd5,
    REG_KD_CURVE     = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
    logic [GAIN_W-1:0] kd;
  } gain_set_t;

  // One item leaving the ring stage towards the multipliers
  typedef struct packed {
    logic                     kind;
    logic signed [ERR_W-1:0]  err;
    logic signed [DIFF_W-1:0] diff;
    logic signed [SUM_W-1:0]  sum;
  } ring_item_t;

endpackage

// ===== hw/rtl/wps_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module wps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold the last read data until the next read
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/wps_ring.sv =====
// Error ring: window memory read-modify-write, running window sum, derivative.
// Depends on wps_pkg and wps_ram.
module wps_ring (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_kind,
  input  logic signed [wps_pkg::ERR_W-1:0] in_err,
  output logic                           out_valid,
  input  logic                           out_ready,
  output wps_pkg::ring_item_t            out_item
);

  logic                             a_valid;
  logic [wps_pkg::SLOT_W-1:0]       a_slot;
  logic signed [wps_pkg::ERR_W-1:0] a_err;
  logic signed [wps_pkg::DIFF_W-1:0] a_diff;
  logic                             a_kind;

  logic [wps_pkg::SLOT_W-1:0]       write_slot;
  logic [wps_pkg::SLOT_W-1:0]       write_slot_next;
  logic signed [wps_pkg::ERR_W-1:0] previous_error;
  logic [wps_pkg::WINDOW-1:0]       filled;
  logic signed [wps_pkg::SUM_W-1:0] history_sum;
  logic signed [wps_pkg::SUM_W-1:0] history_sum_next;

  logic                             b_valid;
  wps_pkg::ring_item_t              b_item;

  logic [wps_pkg::ERR_W-1:0]        rdata;
  logic signed [wps_pkg::ERR_W-1:0] old_err;
  logic                             accept;
  logic                             b_free;
  logic                             mv_a;

  assign b_free   = !b_valid || out_ready;
  assign mv_a     = a_valid && b_free;
  assign in_ready = !a_valid || b_free;
  assign accept   = in_valid && in_ready;

  assign write_slot_next = (write_slot == wps_pkg::SLOT_W'(wps_pkg::WINDOW - 1)) ?
                           '0 : write_slot + 1'b1;

  // A slot never written counts as zero
  assign old_err = filled[a_slot] ? $signed(rdata) : '0;
  assign history_sum_next = history_sum - wps_pkg::SUM_W'(old_err)
                          + wps_pkg::SUM_W'(a_err);

  wps_ram #(
    .WIDTH (wps_pkg::ERR_W),
    .DEPTH (wps_pkg::WINDOW)
  ) u_ring_ram (
    .clk   (clk),
    .we    (mv_a),
    .waddr (a_slot),
    .wdata (a_err),
    .re    (accept),
    .raddr (write_slot),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid        <= 1'b0;
      b_valid        <= 1'b0;
      write_slot     <= '0;
      previous_error <= '0;
      filled         <= '0;
      history_sum    <= '0;
    end else begin
      if (accept) begin
        a_valid        <= 1'b1;
        write_slot     <= write_slot_next;
        previous_error <= in_err;
      end else if (mv_a) begin
        a_valid <= 1'b0;
      end
      if (mv_a) begin
        b_valid        <= 1'b1;
        filled[a_slot] <= 1'b1;
        history_sum    <= history_sum_next;
      end else if (out_ready) begin
        b_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_slot <= write_slot;
      a_err  <= in_err;
      a_diff <= wps_pkg::DIFF_W'(in_err) - wps_pkg::DIFF_W'(previous_error);
      a_kind <= in_kind;
    end
    if (mv_a) begin
      b_item.kind <= a_kind;
      b_item.err  <= a_err;
      b_item.diff <= a_diff;
      b_item.sum  <= history_sum_next;
    end
  end

  assign out_valid = b_valid;
  assign out_item  = b_item;

endmodule

// ===== hw/rtl/wps_arith.sv =====
// Gain multiply, Q8.8 floor and saturation, with the output register.
// Depends on wps_pkg.
module wps_arith (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  wps_pkg::ring_item_t           in_item,
  input  wps_pkg::gain_set_t            gains_straight,
  input  wps_pkg::gain_set_t            gains_curve,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [wps_pkg::STEER_W-1:0]   out_steer
);

  localparam int TURN_W = wps_pkg::ACC_W - 8;
  localparam logic signed [TURN_W-1:0] MaxPos = TURN_W'(wps_pkg::MAX_TURN);
  localparam logic signed [TURN_W-1:0] MaxNeg = -MaxPos;

  wps_pkg::gain_set_t               g;
  logic                             c_valid;
  logic signed [wps_pkg::P_W-1:0]   c_p;
  logic signed [wps_pkg::I_W-1:0]   c_i;
  logic signed [wps_pkg::D_W-1:0]   c_d;
  logic signed [wps_pkg::ACC_W-1:0] acc;
  logic signed [TURN_W-1:0]         turn;
  logic signed [TURN_W-1:0]         sat;
  logic                             o_valid;
  logic [wps_pkg::STEER_W-1:0]      o_steer;
  logic                             o_free;
  logic                             mv_c;
  logic                             take;

  assign o_free   = !o_valid || out_ready;
  assign mv_c     = c_valid && o_free;
  assign in_ready = !c_valid || o_free;
  assign take     = in_valid && in_ready;

  assign g = in_item.kind ? gains_curve : gains_straight;

  // Floor by 8 bits: arithmetic shift rounds toward minus infinity
  assign acc  = wps_pkg::ACC_W'(c_p) + wps_pkg::ACC_W'(c_i) + wps_pkg::ACC_W'(c_d);
  assign turn = acc[wps_pkg::ACC_W-1:8];

  always_comb begin
    sat = turn;
    if (turn > MaxPos) begin
      sat = MaxPos;
    end else if (turn < MaxNeg) begin
      sat = MaxNeg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (take) begin
        c_valid <= 1'b1;
      end else if (mv_c) begin
        c_valid <= 1'b0;
      end
      if (mv_c) begin
        o_valid <= 1'b1;
      end else if (out_ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      c_p <= $signed({1'b0, g.kp}) * $signed(in_item.err);
      c_i <= $signed({1'b0, g.ki}) * $signed(in_item.sum);
      c_d <= $signed({1'b0, g.kd}) * $signed(in_item.diff);
    end
    if (mv_c) begin
      o_steer <= sat[wps_pkg::STEER_W-1:0];
    end
  end

  assign out_valid = o_valid;
  assign out_steer = o_steer;

endmodule

// ===== hw/rtl/windowed_pid_line_steering.sv =====
// Top level of the windowed PID line steering block: configuration registers,
// error ring and arithmetic pipeline. Depends on wps_pkg, wps_ring, wps_arith.
//
// Usage:
//   Input stream s_axis: one sensor sample per transaction; tdata carries
//   sensor_level, tuser carries line_kind (0 straight, 1 curve).
//   Output stream m_axis: one steering command per input transaction; tdata
//   carries steer as an 8-bit two's complement value within +/- MAX_TURN.
//   Configuration: cfg_we with cfg_index and cfg_data writes one register
//   (0 target_level, 1..3 straight gains, 4..6 curve gains, Q8.8). Unknown
//   indexes are ignored. Write only while no sample is in flight.
//   Path: ring stages A and B, multiplier stage C, then the output register.
//   Throughput: one sample per cycle unless the receiver stalls; the ring
//   memory is read at the input transaction and written back one stage later,
//   and the ring length keeps them on different slots, so no interlock is needed.
//   Reset (rst, synchronous): gains and target return to their defaults, the
//   ring reads as all zero through per-slot fill flags, the window sum,
//   previous error and write slot clear, and the pipeline empties.
//   Receiver stall: every stage holds its result and fills any bubble ahead
//   of it; s_axis_tready drops only once all four stages are occupied.
module windowed_pid_line_steering (
  input  logic                              clk,
  input  logic                              rst,
  // slave stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,   // [7:0] sensor_level
  input  logic [0:0]                        s_axis_tuser,   // [0] line_kind
  // master stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [7:0]                        m_axis_tdata,   // [7:0] steer
  // configuration write port
  input  logic                              cfg_we,
  input  logic [wps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wps_pkg::GAIN_W-1:0]        cfg_data
);

  logic [wps_pkg::LEVEL_W-1:0]       target_level;
  wps_pkg::gain_set_t                gains_straight;
  wps_pkg::gain_set_t                gains_curve;
  logic signed [wps_pkg::ERR_W-1:0]  in_err;
  logic                              ring_valid;
  logic                              ring_ready;
  wps_pkg::ring_item_t               ring_item;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      target_level      <= wps_pkg::LEVEL_W'(128);
      gains_straight.kp <= wps_pkg::GAIN_W'(256);
      gains_straight.ki <= '0;
      gains_straight.kd <= '0;
      gains_curve.kp    <= wps_pkg::GAIN_W'(256);
      gains_curve.ki    <= '0;
      gains_curve.kd    <= '0;
    end else if (cfg_we) begin
      case (wps_pkg::cfg_reg_t'(cfg_index))
        wps_pkg::REG_TARGET_LEVEL: target_level      <= cfg_data[wps_pkg::LEVEL_W-1:0];
        wps_pkg::REG_KP_STRAIGHT:  gains_straight.kp <= cfg_data;
        wps_pkg::REG_KI_STRAIGHT:  gains_straight.ki <= cfg_data;
        wps_pkg::REG_KD_STRAIGHT:  gains_straight.kd <= cfg_data;
        wps_pkg::REG_KP_CURVE:     gains_curve.kp    <= cfg_data;
        wps_pkg::REG_KI_CURVE:     gains_curve.ki    <= cfg_data;
        wps_pkg::REG_KD_CURVE:     gains_curve.kd    <= cfg_data;
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  // Error is sample minus target, widened by one sign bit
  assign in_err = $signed({1'b0, s_axis_tdata}) - $signed({1'b0, target_level});

  wps_ring u_ring (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_kind   (s_axis_tuser[0]),
    .in_err    (in_err),
    .out_valid (ring_valid),
    .out_ready (ring_ready),
    .out_item  (ring_item)
  );

  wps_arith u_arith (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (ring_valid),
    .in_ready       (ring_ready),
    .in_item        (ring_item),
    .gains_straight (gains_straight),
    .gains_curve    (gains_curve),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .out_steer      (m_axis_tdata)
  );

  // Steering command never leaves the saturation band
  a_steer_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (wps_pkg::MAX_TURN > 127) ||
      (($signed(m_axis_tdata) <= wps_pkg::MAX_TURN) &&
       ($signed(m_axis_tdata) >= -wps_pkg::MAX_TURN)))
    else $error("steer outside saturation band");

  // A ring result stalled by the multiplier stage holds its contents
  a_ring_hold: assert property (@(posedge clk) disable iff (rst)
    ring_valid && !ring_ready |=> ring_valid && $stable(ring_item))
    else $error("ring result changed while stalled");

  // Input back-pressure only when the ring stage is occupied
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> ring_valid && !ring_ready)
    else $error("input stalled with room in the pipeline");

  // Pipeline empties on reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid && !ring_valid)
    else $error("pipeline not empty after reset");

endmodule

// ===== dv/wps_checker.sv =====
// Scoreboard for the windowed PID line steering block: follows the configuration writes and
// both streams, predicts each steering command and compares it with the one that arrives.
// Depends on wps_pkg for widths, the register enum and the gain set type.
`timescale 1ns / 1ps

module wps_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // [7:0] sensor_level
  input  logic [0:0]                    s_axis_tuser,   // [0] line_kind
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [7:0]                    m_axis_tdata,   // [7:0] steer
  input  logic                          cfg_we,
  input  logic [wps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wps_pkg::GAIN_W-1:0]    cfg_data,
  output int                            mismatches,
  output int                            outstanding
);
  import wps_pkg::*;

  logic [LEVEL_W-1:0]       target;
  gain_set_t                straight_gains;
  gain_set_t                curve_gains;
  logic signed [ERR_W-1:0]  err_ring [WINDOW];
  logic signed [SUM_W-1:0]  err_sum;
  logic [SLOT_W-1:0]        ring_slot;
  logic signed [ERR_W-1:0]  last_err;
  logic [STEER_W-1:0]       steer_queue [$];

  // Advance the controller state by one sample and return the steering command.
  function automatic logic [STEER_W-1:0] next_steer(input logic kind,
                                                     input logic [LEVEL_W-1:0] level);
    gain_set_t                g;
    logic signed [ERR_W-1:0]  err;
    logic signed [DIFF_W-1:0] diff;
    longint                   acc;
    longint                   turn;
    g = kind ? curve_gains : straight_gains;
    err = $signed({1'b0, level}) - $signed({1'b0, target});
    err_sum = err_sum - err_ring[ring_slot] + err;
    err_ring[ring_slot] = err;
    diff = err - last_err;
    last_err = err;
    ring_slot = (ring_slot == SLOT_W'(WINDOW - 1)) ? '0 : ring_slot + 1'b1;
    acc = longint'(g.kp) * longint'(err) + longint'(g.ki) * longint'(err_sum)
        + longint'(g.kd) * longint'(diff);
    // arithmetic shift floors toward minus infinity
    turn = acc >>> 8;
    if (turn > MAX_TURN)
      turn = MAX_TURN;
    else if (turn < -MAX_TURN)
      turn = -MAX_TURN;
    return turn[STEER_W-1:0];
  endfunction

  always @(posedge clk) begin
    logic [STEER_W-1:0] want;
    if (rst) begin
      target = 8'd128;
      straight_gains = '{kp: 16'd256, ki: 16'd0, kd: 16'd0};
      curve_gains    = '{kp: 16'd256, ki: 16'd0, kd: 16'd0};
      for (int i = 0; i < WINDOW; i++)
        err_ring[i] = '0;
      err_sum = '0;
      ring_slot = '0;
      last_err = '0;
      steer_queue.delete();
      mismatches <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_TARGET_LEVEL: target = cfg_data[LEVEL_W-1:0];
          REG_KP_STRAIGHT:  straight_gains.kp = cfg_data;
          REG_KI_STRAIGHT:  straight_gains.ki = cfg_data;
          REG_KD_STRAIGHT:  straight_gains.kd = cfg_data;
          REG_KP_CURVE:     curve_gains.kp = cfg_data;
          REG_KI_CURVE:     curve_gains.ki = cfg_data;
          REG_KD_CURVE:     curve_gains.kd = cfg_data;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        steer_queue.push_back(next_steer(s_axis_tuser[0], s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (steer_queue.size() == 0) begin
          $display("%0t: steer with nothing expected, actual %0d", $time,
                   $signed(m_axis_tdata));
          mismatches <= mismatches + 1;
        end else begin
          want = steer_queue.pop_front();
          if (want !== m_axis_tdata) begin
            $display("%0t: steer expected %0d, actual %0d", $time, $signed(want),
                     $signed(m_axis_tdata));
            mismatches <= mismatches + 1;
          end
        end
      end
    end
    outstanding <= steer_queue.size();
  end

endmodule

// ===== dv/tb_top.sv =====
// Top of the windowed PID line steering testbench: clock, reset, register programming,
// sample stimulus with random idling and the final verdict.
// Depends on wps_pkg, wps_checker and the windowed_pid_line_steering block.
`timescale 1ns / 1ps

module tb_top;
  import wps_pkg::*;

  localparam int NUM_REGS      = 7;
  localparam int PHASES        = 8;
  localparam int PHASE_SAMPLES = 62;
  localparam int SETTLE_CYCLES = 10;     // margin beyond the pipeline latency
  localparam int CYCLE_LIMIT   = 200000;
  // index with no register behind it; the block must drop such writes
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  // Hand-picked opening samples, {line_kind, sensor_level}: both gain sets, both
  // ends of the sensor range, small errors either side of the target (floor of
  // negative sums), and enough steps to wrap the error ring twice.
  localparam logic [8:0] OPENING [20] = '{
    9'h080, 9'h081, 9'h07F, 9'h183, 9'h17D, 9'h0FF, 9'h100, 9'h0FF, 9'h1FF, 9'h000,
    9'h100, 9'h082, 9'h07E, 9'h180, 9'h084, 9'h17C, 9'h080, 9'h180, 9'h080, 9'h080
  };

  logic                 clk;
  logic                 rst;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata;   // [7:0] sensor_level
  logic [0:0]           s_axis_tuser;   // [0] line_kind
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [7:0]           m_axis_tdata;   // [7:0] steer
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [GAIN_W-1:0]    cfg_data;

  int                   mismatches;
  int                   outstanding;
  int                   send_idle_pct;
  int                   recv_stall_pct;
  int                   cycle_count;
  logic [GAIN_W-1:0]    reg_image [NUM_REGS];

  windowed_pid_line_steering dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  wps_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: stall at random at the current rate; a rate of zero keeps tready high.
  initial m_axis_tready = 1'b0;
  always @(negedge clk)
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

  // Watchdog: end the run as failed once cycle_count reaches CYCLE_LIMIT.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

  // Write every register from reg_image, then poke the unused index with junk.
  // Hold cfg_we high across the whole burst and drop it once at the end.
  task automatic program_registers();
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= reg_image[i];
      @(negedge clk);
    end
    cfg_we    <= 1'b1;
    cfg_index <= REG_UNUSED;
    cfg_data  <= GAIN_W'($urandom);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Offer one sample, idling beforehand at the current rate, and hold it until the
  // transaction completes. Returns at the falling edge after acceptance.
  task automatic send_sample(input logic kind, input logic [7:0] level);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= level;
    s_axis_tuser  <= kind;
    while (1) begin
      @(posedge clk);
      if (s_axis_tready)
        break;
    end
    @(negedge clk);
  endtask

  // Drop tvalid and wait until every predicted command has been taken, plus the
  // pipeline latency, so the block is idle for register writes.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Pick the register settings of one random phase; extremes on fixed phases.
  task automatic choose_settings(input int phase);
    case (phase)
      1: begin
        // every gain at full scale, target at the bottom: saturation everywhere
        reg_image[REG_TARGET_LEVEL] = 16'h0000;
        for (int i = REG_KP_STRAIGHT; i < NUM_REGS; i++)
          reg_image[i] = 16'hFFFF;
      end
      2: begin
        // all gains zero, target at the top
        reg_image[REG_TARGET_LEVEL] = 16'hFFFF;
        for (int i = REG_KP_STRAIGHT; i < NUM_REGS; i++)
          reg_image[i] = 16'h0000;
      end
      4: begin
        reg_image[REG_TARGET_LEVEL] = 16'h00FF;
        reg_image[REG_KP_STRAIGHT]  = 16'hFFFF;
        reg_image[REG_KP_CURVE]     = 16'hFFFF;
        reg_image[REG_KI_STRAIGHT]  = GAIN_W'($urandom);
        reg_image[REG_KD_STRAIGHT]  = GAIN_W'($urandom);
        reg_image[REG_KI_CURVE]     = GAIN_W'($urandom);
        reg_image[REG_KD_CURVE]     = GAIN_W'($urandom);
      end
      5: begin
        for (int i = 0; i < NUM_REGS; i++)
          reg_image[i] = GAIN_W'($urandom);
      end
      default: begin
        // moderate gains keep most commands inside the saturation limits
        reg_image[REG_TARGET_LEVEL] = GAIN_W'($urandom_range(0, 255));
        reg_image[REG_KP_STRAIGHT]  = GAIN_W'($urandom_range(0, 1023));
        reg_image[REG_KI_STRAIGHT]  = GAIN_W'($urandom_range(0, phase == 6 ? 1023 : 127));
        reg_image[REG_KD_STRAIGHT]  = GAIN_W'($urandom_range(0, 1023));
        reg_image[REG_KP_CURVE]     = GAIN_W'($urandom_range(0, 1023));
        reg_image[REG_KI_CURVE]     = GAIN_W'($urandom_range(0, phase == 6 ? 1023 : 127));
        reg_image[REG_KD_CURVE]     = GAIN_W'($urandom_range(0, 1023));
      end
    endcase
  endtask

  initial begin
    int   lvl;
    logic [LEVEL_W-1:0] tgt;
    rst            <= 1'b1;
    s_axis_tvalid  <= 1'b0;
    s_axis_tdata   <= '0;
    s_axis_tuser   <= '0;
    cfg_we         <= 1'b0;
    cfg_index      <= '0;
    cfg_data       <= '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Opening part: ring still all zero, so the first steps see empty slots and a
    // previous error of zero. The target value carries junk in its upper bits,
    // which the block must mask off (it reads as 128).
    reg_image = '{16'hFF80, 16'h0180, 16'h0020, 16'h0100, 16'h0300, 16'h0040, 16'h0200};
    program_registers();
    foreach (OPENING[i])
      send_sample(OPENING[i][8], OPENING[i][7:0]);

    // Random phases: new settings each time, idling mode cycling through none,
    // sender only, receiver only and both.
    for (int phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      choose_settings(phase);
      program_registers();
      case (phase % 4)
        1: send_idle_pct = 45;
        2: recv_stall_pct = 45;
        3: begin
          send_idle_pct  = 34;
          recv_stall_pct = 34;
        end
        default: ;
      endcase
      tgt = reg_image[REG_TARGET_LEVEL][LEVEL_W-1:0];
      for (int n = 0; n < PHASE_SAMPLES; n++) begin
        // mid-phase, hold the sender until the pipeline has emptied completely
        if (phase == 5 && n == PHASE_SAMPLES / 2)
          wait_drained();
        // mostly readings close to the target, the rest across the full range
        if ($urandom_range(0, 99) < 70) begin
          lvl = int'(tgt) + int'($urandom_range(0, 32)) - 16;
          if (lvl < 0)
            lvl = 0;
          else if (lvl > 255)
            lvl = 255;
        end else begin
          lvl = $urandom_range(0, 255);
        end
        send_sample(1'($urandom_range(0, 1)), 8'(lvl));
      end
    end

    wait_drained();
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/wps_pkg.sv
hw/rtl/wps_ram.sv
hw/rtl/wps_ring.sv
hw/rtl/wps_arith.sv
hw/rtl/windowed_pid_line_steering.sv
dv/wps_checker.sv
dv/tb_top.sv
